[sv/grmd_pkg.sv]
// grid ray march distance: shared types, constants and the quarter-wave sine table
// used by the controller, the datapath and the top level; no dependencies
`default_nettype none

package grmd_pkg;

  // physical map geometry
  localparam int MAP_SIDE = 64;
  localparam int MAP_BITS = $clog2(MAP_SIDE);
  localparam int CELLS    = MAP_SIDE * MAP_SIDE;
  localparam int ADDR_W   = $clog2(CELLS);

  // coordinates are Q.14, wide enough for origin plus 257 steps of a unit vector
  localparam int FRAC_W = 14;
  localparam int ACC_W  = 24;
  localparam int DIR_W  = 16;

  // item operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CAST  = 1'b1;

  // configuration register indexes
  localparam logic [1:0] CFG_MAP_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_MAP_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_MAX_STEPS  = 2'd2;

  localparam logic [6:0] MAP_WIDTH_RST  = 7'd64;
  localparam logic [6:0] MAP_HEIGHT_RST = 7'd64;
  localparam logic [7:0] MAX_STEPS_RST  = 8'd200;

  typedef struct packed {
    logic load;
    logic clear;
    logic write_cell;
    logic march_step;
    logic out_fire;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic march_done;
  } status_t;

  typedef struct packed {
    logic                ok;
    logic [MAP_BITS-1:0] idx;
  } cell_t;

  typedef logic [14:0] qtab_t [0:255];

  // odd polynomial for the first quarter wave, evaluated at elaboration only
  function automatic logic [14:0] quarter_entry(input int unsigned q);
    longint unsigned z;
    longint unsigned z2;
    longint unsigned r;
    longint unsigned s;
    z  = longint'(q) * 64'd256;
    z2 = (z * z) >> 16;
    r  = 64'd11;
    r  = 64'd307 - ((r * z2) >> 16);
    r  = 64'd5223 - ((r * z2) >> 16);
    r  = 64'd42334 - ((r * z2) >> 16);
    r  = 64'd102944 - ((r * z2) >> 16);
    s  = (((r * z) >> 16) + 64'd2) >> 2;
    if (s > 64'd16384) s = 64'd16384;
    return s[14:0];
  endfunction

  function automatic qtab_t build_qtab();
    qtab_t t;
    for (int i = 0; i < 256; i++) t[i] = quarter_entry(i);
    return t;
  endfunction

  localparam qtab_t       QTAB = build_qtab();
  localparam logic [14:0] QTOP = quarter_entry(256);

  // sine of a 1024-per-turn phase, Q2.14
  function automatic logic signed [DIR_W-1:0] phase_sine(input logic [9:0] p);
    logic [8:0]  idx;
    logic [14:0] mag;
    logic signed [DIR_W-1:0] v;
    idx = p[8] ? (9'd256 - {1'b0, p[7:0]}) : {1'b0, p[7:0]};
    mag = idx[8] ? QTOP : QTAB[idx[7:0]];
    v   = $signed({1'b0, mag});
    return p[9] ? -v : v;
  endfunction

  // Q.14 coordinate cut toward zero, checked against the rows or columns in use
  function automatic cell_t cut_cell(input logic signed [ACC_W-1:0] s, input logic [6:0] lim);
    cell_t c;
    logic [ACC_W-FRAC_W-2:0] whole;
    whole = s[ACC_W-2:FRAC_W];
    if (s[ACC_W-1]) begin
      // only a value in (-1, 0) lands on cell 0
      c.ok  = (&s[ACC_W-1:FRAC_W]) && (|s[FRAC_W-1:0]) && (lim != 7'd0);
      c.idx = '0;
    end else begin
      c.ok  = whole < {{(ACC_W-FRAC_W-8){1'b0}}, lim};
      c.idx = s[FRAC_W+MAP_BITS-1:FRAC_W];
    end
    return c;
  endfunction

endpackage

`default_nettype wire

[sv/grmd_ram.sv]
// generic single-write, single-read RAM with registered read data
// no dependencies
`default_nettype none

module grmd_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

[sv/grmd_ctrl.sv]
// grid ray march distance: controller state machine
// depends on grmd_pkg for the command and status structs and op codes
`default_nettype none

module grmd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic              in_operation,
  output logic              busy,
  output logic              out_valid,
  output grmd_pkg::cmd_t    cmd,
  input  grmd_pkg::status_t status
);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_MARCH
  } state_t;

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (status.clear_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        cmd.load = start;
        if (start) state_nxt = (in_operation == grmd_pkg::OP_CAST) ? ST_MARCH : ST_WRITE;
      end
      ST_WRITE: begin
        cmd.write_cell = 1'b1;
        state_nxt      = ST_IDLE;
      end
      ST_MARCH: begin
        cmd.march_step = 1'b1;
        cmd.out_fire   = status.march_done;
        if (status.march_done) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= cmd.out_fire;
    end
  end

  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

[sv/grmd_dpath.sv]
// grid ray march distance: datapath with config registers, wall map, direction
// lookup, position accumulators and the step pipeline; depends on grmd_pkg, grmd_ram
`default_nettype none

module grmd_dpath (
  input  logic              clk,
  input  logic              rst_n,
  input  grmd_pkg::cmd_t    cmd,
  output grmd_pkg::status_t status,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [7:0]        cfg_data,
  input  logic [5:0]        in_cell_x,
  input  logic [5:0]        in_cell_y,
  input  logic              in_cell_wall,
  input  logic [13:0]       in_player_x,
  input  logic [13:0]       in_player_y,
  input  logic [9:0]        in_ray_angle,
  output logic [7:0]        out_distance,
  output logic              out_hit
);

  logic [6:0] map_width_r;
  logic [6:0] map_height_r;
  logic [7:0] max_steps_r;
  logic [6:0] w_eff;
  logic [6:0] h_eff;

  logic [grmd_pkg::MAP_BITS-1:0] cell_x_r;
  logic [grmd_pkg::MAP_BITS-1:0] cell_y_r;
  logic                          wall_r;

  logic signed [grmd_pkg::DIR_W-1:0] dir_x_r;
  logic signed [grmd_pkg::DIR_W-1:0] dir_y_r;
  logic signed [grmd_pkg::ACC_W-1:0] acc_x_r;
  logic signed [grmd_pkg::ACC_W-1:0] acc_y_r;

  logic [7:0] d_iss_r;
  logic [7:0] d_chk_r;
  logic       chk_vld_r;
  logic       in_x_r;
  logic       in_y_r;
  logic       issue_ok;
  logic       is_wall;

  logic [grmd_pkg::ADDR_W-1:0] clr_cnt_r;

  grmd_pkg::cell_t cx;
  grmd_pkg::cell_t cy;

  logic                        ram_we;
  logic [grmd_pkg::ADDR_W-1:0] ram_waddr;
  logic                        ram_wdata;
  logic [grmd_pkg::ADDR_W-1:0] ram_raddr;
  logic                        ram_rdata;

  logic [7:0] out_distance_r;
  logic       out_hit_r;

  // configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      map_width_r  <= grmd_pkg::MAP_WIDTH_RST;
      map_height_r <= grmd_pkg::MAP_HEIGHT_RST;
      max_steps_r  <= grmd_pkg::MAX_STEPS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        grmd_pkg::CFG_MAP_WIDTH:  map_width_r  <= cfg_data[6:0];
        grmd_pkg::CFG_MAP_HEIGHT: map_height_r <= cfg_data[6:0];
        grmd_pkg::CFG_MAX_STEPS:  max_steps_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_eff = (map_width_r > 7'(grmd_pkg::MAP_SIDE)) ? 7'(grmd_pkg::MAP_SIDE) : map_width_r;
  assign h_eff = (map_height_r > 7'(grmd_pkg::MAP_SIDE)) ? 7'(grmd_pkg::MAP_SIDE) : map_height_r;

  // clearing sweep counter
  always_ff @(posedge clk) begin
    if (!rst_n) clr_cnt_r <= '0;
    else if (cmd.clear) clr_cnt_r <= clr_cnt_r + 1'b1;
  end

  assign status.clear_last = &clr_cnt_r;

  // sample cells of the current step
  assign cx        = grmd_pkg::cut_cell(acc_x_r, w_eff);
  assign cy        = grmd_pkg::cut_cell(acc_y_r, h_eff);
  assign issue_ok  = (d_iss_r != max_steps_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chk_vld_r <= 1'b0;
      d_iss_r   <= '0;
    end else if (cmd.load) begin
      chk_vld_r <= 1'b0;
      d_iss_r   <= '0;
    end else if (cmd.march_step) begin
      chk_vld_r <= issue_ok;
      if (issue_ok) d_iss_r <= d_iss_r + 8'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cell_x_r <= in_cell_x;
      cell_y_r <= in_cell_y;
      wall_r   <= in_cell_wall;
      dir_x_r  <= grmd_pkg::phase_sine(in_ray_angle + 10'd256);
      dir_y_r  <= grmd_pkg::phase_sine(in_ray_angle);
      acc_x_r  <= $signed({{(grmd_pkg::ACC_W-20){1'b0}}, in_player_x, 6'd0});
      acc_y_r  <= $signed({{(grmd_pkg::ACC_W-20){1'b0}}, in_player_y, 6'd0});
    end else if (cmd.march_step) begin
      acc_x_r <= acc_x_r + grmd_pkg::ACC_W'(dir_x_r);
      acc_y_r <= acc_y_r + grmd_pkg::ACC_W'(dir_y_r);
      d_chk_r <= d_iss_r;
      in_x_r  <= cx.ok;
      in_y_r  <= cy.ok;
    end
  end

  // wall map: sweep clear after reset, then cell writes
  assign ram_we    = cmd.clear | cmd.write_cell;
  assign ram_waddr = cmd.clear ? clr_cnt_r : {cell_y_r, cell_x_r};
  assign ram_wdata = cmd.clear ? 1'b0 : wall_r;
  assign ram_raddr = {cy.idx, cx.idx};

  grmd_ram #(
    .WIDTH(1),
    .DEPTH(grmd_pkg::CELLS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // read data of the step issued last cycle
  assign is_wall           = chk_vld_r && in_x_r && in_y_r && ram_rdata;
  assign status.march_done = is_wall || (!chk_vld_r && (d_iss_r == max_steps_r));

  always_ff @(posedge clk) begin
    if (cmd.out_fire) begin
      out_distance_r <= is_wall ? d_chk_r : d_iss_r;
      out_hit_r      <= is_wall;
    end
  end

  assign out_distance = out_distance_r;
  assign out_hit      = out_hit_r;

endmodule

`default_nettype wire

[sv/grid_ray_march_distance.sv]
// grid ray march distance: top level joining controller and datapath
// depends on grmd_pkg, grmd_ctrl, grmd_dpath (which holds grmd_ram)
//
// Usage:
//   An item is taken when start is high and busy is low. in_operation selects
//   a cell write (in_cell_x, in_cell_y, in_cell_wall) or a ray cast
//   (in_player_x, in_player_y in Q6.8 cells, in_ray_angle in 1/1024 turns).
//   A write gives no result; busy stays high while the cell is written.
//   A cast gives one result beat: out_valid is high for one cycle with
//   out_distance and out_hit. The march takes one wall map read per step,
//   pipelined through the registered map read. A cast that hits a wall at
//   step d gives out_distance d with out_hit high, and a miss gives
//   out_distance max_steps with out_hit low.
//   busy drops in the result cycle, so a new item can be taken there.
//   The receiver cannot stall; each result is present for exactly one cycle.
//   cfg_we, cfg_index, cfg_data write map_width (0), map_height (1) and
//   max_steps (2); other indexes are ignored.
//   After reset the wall map is swept clear, one cell a cycle, with busy
//   high; configuration writes are taken during the sweep.
`default_nettype none

module grid_ray_march_distance (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_operation,
  input  logic [5:0]  in_cell_x,
  input  logic [5:0]  in_cell_y,
  input  logic        in_cell_wall,
  input  logic [13:0] in_player_x,
  input  logic [13:0] in_player_y,
  input  logic [9:0]  in_ray_angle,
  output logic        out_valid,
  output logic [7:0]  out_distance,
  output logic        out_hit,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_data
);

  grmd_pkg::cmd_t    cmd;
  grmd_pkg::status_t status;

  grmd_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .in_operation(in_operation),
    .busy        (busy),
    .out_valid   (out_valid),
    .cmd         (cmd),
    .status      (status)
  );

  grmd_dpath u_dpath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .status      (status),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .in_cell_x   (in_cell_x),
    .in_cell_y   (in_cell_y),
    .in_cell_wall(in_cell_wall),
    .in_player_x (in_player_x),
    .in_player_y (in_player_y),
    .in_ray_angle(in_ray_angle),
    .out_distance(out_distance),
    .out_hit     (out_hit)
  );

endmodule

`default_nettype wire
